/* src/mtat_pkg.sv */
// ----------------------------------------------------------------------------
// Multiturn angle tracker package
// Shared types and fixed constants for the multiturn angle tracker.
// ----------------------------------------------------------------------------
package mtat_pkg;

    typedef enum logic
    {
        KIND_INIT   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    localparam int COUNT_W  = 32;
    localparam int TURN_W   = 20;
    localparam int FANGLE_W = 38;
    localparam int COEFF_W  = 17;
    localparam int Q_SHIFT  = 16;

    localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;

    // The degree scale 184320 equals 45 times two to the twelfth.
    localparam int DEG_REF_BITS = 12;
    localparam logic signed [FANGLE_W-1:0] DEG_MULT = 38'sd45;
    localparam logic signed [33:0] INT32_HI = 34'sd2147483647;
    localparam logic signed [33:0] INT32_LO = -34'sd2147483648;
    localparam logic signed [33:0] TURN_HI  = 34'sd524287;
    localparam logic signed [33:0] TURN_LO  = -34'sd524288;

    typedef struct packed
    {
        logic updated;
        logic clear;
        logic armed;
    } stage_ctl_t;

endpackage

/* src/mtat_ifs.sv */
// ----------------------------------------------------------------------------
// Multiturn angle tracker channel interfaces
// Valid/ready channels for sensor items and tracking results.
// ----------------------------------------------------------------------------
interface mtat_in_if
    import mtat_pkg::*;
#(
    parameter int ANGLE_BITS = 12
);
    logic                  valid;
    logic                  ready;
    kind_t                 kind;
    logic [ANGLE_BITS-1:0] angle_sample;
    logic                  magnet_present;

    modport source (output valid, output kind, output angle_sample, output magnet_present,
                    input ready);
    modport sink   (input valid, input kind, input angle_sample, input magnet_present,
                    output ready);
endinterface

interface mtat_out_if
    import mtat_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       updated;
    logic signed [COUNT_W-1:0]  total_counts;
    logic signed [TURN_W-1:0]   turn_count;
    logic signed [FANGLE_W-1:0] filtered_angle;
    logic                       armed;

    modport source (output valid, output updated, output total_counts, output turn_count,
                    output filtered_angle, output armed, input ready);
    modport sink   (input valid, input updated, input total_counts, input turn_count,
                    input filtered_angle, input armed, output ready);
endinterface

/* src/multiturn_angle_tracker_core.sv */
// ----------------------------------------------------------------------------
// Multiturn angle tracker core
// Tracks a multiturn position from absolute angle samples and reports the
// saturating count, whole turns and a filtered angle in 1/512 degree.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Payload
//  sample    in         valid/ready     kind, angle_sample, magnet_present
//  result    out        valid/ready     updated, total_counts, turn_count,
//                                       filtered_angle, armed
//  cfg       in         cfg_we          cfg_data (filter coefficient)
//
// One transaction per cycle is accepted while no stalled result holds the
// stages. The unwrap and count update run in the first stage,
// the filter multiply-accumulate in the second, whose register is the output.
// Reset clears tracking state and sets the filter coefficient to unity.
// A stalled result holds both stages; input is taken again as soon as the
// first stage can move.
// ----------------------------------------------------------------------------
module multiturn_angle_tracker_core
    import mtat_pkg::*;
#(
    parameter int ANGLE_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COEFF_W-1:0] cfg_data,
    mtat_in_if.sink            sample,
    mtat_out_if.source         result
);

    localparam int XW = FANGLE_W +
                        ((ANGLE_BITS < DEG_REF_BITS) ? (DEG_REF_BITS - ANGLE_BITS) : 0);

    logic [COEFF_W-1:0]        coeff_reg;
    logic                      a_valid_reg;
    logic                      out_valid_reg;
    logic                      updated_reg;
    logic signed [COUNT_W-1:0] count_out_reg;
    logic signed [TURN_W-1:0]  turns_out_reg;
    logic                      armed_out_reg;
    logic                      advance;
    logic                      in_fire;
    logic                      move;
    stage_ctl_t                a_ctl;
    logic signed [COUNT_W-1:0] a_count;
    logic signed [TURN_W-1:0]  a_turns;
    logic signed [XW-1:0]      a_x;

    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !a_valid_reg || advance;
    assign in_fire      = sample.valid && sample.ready;
    assign move         = a_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_ONE;
        end
        else if (cfg_we)
        begin
            coeff_reg <= (cfg_data > COEFF_ONE) ? COEFF_ONE : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_fire || (a_valid_reg && !advance);
            if (advance)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            updated_reg   <= a_ctl.updated;
            count_out_reg <= a_count;
            turns_out_reg <= a_turns;
            armed_out_reg <= a_ctl.armed;
        end
    end

    mtat_unwrap #(
        .ANGLE_BITS (ANGLE_BITS),
        .XW         (XW)
    ) u_unwrap (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_fire),
        .kind   (sample.kind),
        .angle  (ANGLE_BITS'(sample.angle_sample)),
        .magnet (sample.magnet_present),
        .ctl    (a_ctl),
        .count  (a_count),
        .turns  (a_turns),
        .x      (a_x)
    );

    mtat_filter #(
        .XW (XW)
    ) u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (move),
        .ctl            (a_ctl),
        .x              (a_x),
        .coeff          (coeff_reg),
        .filtered_angle (result.filtered_angle)
    );

    assign result.valid        = out_valid_reg;
    assign result.updated      = updated_reg;
    assign result.total_counts = count_out_reg;
    assign result.turn_count   = turns_out_reg;
    assign result.armed        = armed_out_reg;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !advance |=> a_valid_reg)
        else $error("First stage lost a transaction while stalled.");

    init_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && sample.kind == KIND_INIT |=> a_count == '0 && !a_ctl.updated)
        else $error("Init transaction did not clear the count.");

    updated_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.updated |-> result.armed)
        else $error("Updated result reported while not armed.");

    coeff_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        coeff_reg <= COEFF_ONE)
        else $error("Filter coefficient above unity.");

    init_clears_filter: assert property (@(posedge clk) disable iff (!rst_n)
        move && a_ctl.clear |=> result.filtered_angle == '0)
        else $error("Init transaction did not clear the filter.");
`endif

endmodule

/* src/mtat_unwrap.sv */
// ----------------------------------------------------------------------------
// Multiturn angle tracker unwrap stage
// Unwraps the angle step, accumulates the saturating count and derives
// turns and the total angle in 1/512 degree units.
// ----------------------------------------------------------------------------
module mtat_unwrap
    import mtat_pkg::*;
#(
    parameter int ANGLE_BITS = 12,
    parameter int XW         = 38
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  kind_t                 kind,
    input  logic [ANGLE_BITS-1:0] angle,
    input  logic                  magnet,
    output stage_ctl_t            ctl,
    output logic signed [COUNT_W-1:0] count,
    output logic signed [TURN_W-1:0]  turns,
    output logic signed [XW-1:0]      x
);

    localparam int DW    = ANGLE_BITS + 2;
    localparam int SH_L  = (ANGLE_BITS < DEG_REF_BITS) ? (DEG_REF_BITS - ANGLE_BITS) : 0;
    localparam int SH_R  = (ANGLE_BITS > DEG_REF_BITS) ? (ANGLE_BITS - DEG_REF_BITS) : 0;
    localparam logic signed [DW-1:0] FULL_TURN = DW'(1) <<< ANGLE_BITS;
    localparam logic signed [DW-1:0] HALF_TURN = DW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [33:0]   TURN_BIAS = (34'sd1 <<< ANGLE_BITS) - 34'sd1;

    logic                            armed_reg;
    logic                            armed_next;
    logic [ANGLE_BITS-1:0]           prev_angle_reg;
    logic [ANGLE_BITS-1:0]           prev_angle_next;
    logic signed [COUNT_W-1:0]       count_reg;
    logic signed [COUNT_W-1:0]       count_next;
    stage_ctl_t                      ctl_reg;
    stage_ctl_t                      ctl_next;
    logic signed [TURN_W-1:0]        turns_reg;
    logic signed [TURN_W-1:0]        turns_next;
    logic signed [XW-1:0]            x_reg;
    logic signed [XW-1:0]            x_next;
    logic signed [DW-1:0]            d_raw;
    logic signed [DW-1:0]            d;
    logic signed [33:0]              sum;
    logic signed [33:0]              t_wide;
    logic signed [FANGLE_W-1:0]      x45;
    logic                            upd;

    always_comb
    begin
        upd   = (kind == KIND_SAMPLE) && armed_reg && magnet;
        d_raw = $signed({2'b00, angle}) - $signed({2'b00, prev_angle_reg});
        if (d_raw > HALF_TURN)
        begin
            d = d_raw - FULL_TURN;
        end
        else if (d_raw < -HALF_TURN)
        begin
            d = d_raw + FULL_TURN;
        end
        else
        begin
            d = d_raw;
        end
        sum = 34'(count_reg) + 34'(d);

        armed_next      = armed_reg;
        prev_angle_next = prev_angle_reg;
        count_next      = count_reg;
        if (kind == KIND_INIT)
        begin
            armed_next      = magnet;
            prev_angle_next = '0;
            count_next      = '0;
        end
        else if (upd)
        begin
            prev_angle_next = angle;
            if (sum > INT32_HI)
            begin
                count_next = COUNT_W'(INT32_HI);
            end
            else if (sum < INT32_LO)
            begin
                count_next = COUNT_W'(INT32_LO);
            end
            else
            begin
                count_next = COUNT_W'(sum);
            end
        end

        ctl_next.updated = upd;
        ctl_next.clear   = (kind == KIND_INIT);
        ctl_next.armed   = armed_next;

        x45 = FANGLE_W'(count_next) * DEG_MULT;
        if (ANGLE_BITS <= DEG_REF_BITS)
        begin
            x_next = XW'(x45) <<< SH_L;
        end
        else
        begin
            x_next = XW'(x45 >>> SH_R);
        end

        // Truncation toward zero: bias negative counts before the shift.
        if (count_next < 0)
        begin
            t_wide = (34'(count_next) + TURN_BIAS) >>> ANGLE_BITS;
        end
        else
        begin
            t_wide = 34'(count_next) >>> ANGLE_BITS;
        end
        if (t_wide > TURN_HI)
        begin
            turns_next = TURN_W'(TURN_HI);
        end
        else if (t_wide < TURN_LO)
        begin
            turns_next = TURN_W'(TURN_LO);
        end
        else
        begin
            turns_next = TURN_W'(t_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            prev_angle_reg <= '0;
            count_reg      <= '0;
        end
        else if (load)
        begin
            armed_reg      <= armed_next;
            prev_angle_reg <= prev_angle_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= ctl_next;
            turns_reg <= turns_next;
            x_reg     <= x_next;
        end
    end

    assign ctl   = ctl_reg;
    assign count = count_reg;
    assign turns = turns_reg;
    assign x     = x_reg;

endmodule

/* src/mtat_filter.sv */
// ----------------------------------------------------------------------------
// Multiturn angle tracker filter stage
// First-order low-pass filter of the total angle with a Q1.16 weight,
// rounded half up.
// ----------------------------------------------------------------------------
module mtat_filter
    import mtat_pkg::*;
#(
    parameter int XW = 38
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  stage_ctl_t                 ctl,
    input  logic signed [XW-1:0]       x,
    input  logic [COEFF_W-1:0]         coeff,
    output logic signed [FANGLE_W-1:0] filtered_angle
);

    localparam int PW = XW + COEFF_W + 2;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (Q_SHIFT - 1);

    logic signed [XW-1:0] p_reg;
    logic signed [XW-1:0] p_next;
    logic signed [XW:0]   diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] adj;

    // c*x + (1-c)*p is rewritten as p + c*(x-p), which needs one multiplier.
    always_comb
    begin
        diff = (XW+1)'(x) - (XW+1)'(p_reg);
        prod = PW'($signed({1'b0, coeff})) * PW'(diff);
        adj  = (prod + ROUND_HALF) >>> Q_SHIFT;
        if (ctl.clear)
        begin
            p_next = '0;
        end
        else if (ctl.updated)
        begin
            p_next = p_reg + XW'(adj);
        end
        else
        begin
            p_next = p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else if (load)
        begin
            p_reg <= p_next;
        end
    end

    assign filtered_angle = FANGLE_W'(p_reg);

endmodule
